@@ hw/rtl/teq_pkg.sv @@
// Package: types, constants and codes for the timed event queue.
package teq_pkg;
    localparam int QueueDepth = 32;
    localparam int IdBits     = 16;
    localparam int IdxW       = $clog2(QueueDepth);
    localparam int CntW       = $clog2(QueueDepth + 1);

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [2:0] K_ADDED    = 3'd0;
    localparam logic [2:0] K_REJ_PAST = 3'd1;
    localparam logic [2:0] K_REJ_FULL = 3'd2;
    localparam logic [2:0] K_REMOVED  = 3'd3;
    localparam logic [2:0] K_FIRED    = 3'd4;
    localparam logic [2:0] K_DONE     = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] time_value;
        logic [15:0] event_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] fired_id;
        logic [31:0] fired_time;
        logic [5:0]  removed_count;
        logic [31:0] now_time;
        logic        last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_SHIFT, S_SCAN, S_FIRE, S_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch input item
        logic add_step;  // one step of add search/shift
        logic scan_step; // one step of remove/advance compaction
        logic fire_take; // fired entry transferred out
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic add_done;
        logic scan_done;
        logic fire_pend;
    } t_stat;
endpackage

@@ hw/rtl/teq_datapath.sv @@
// Datapath: slot register file, time register, shift/compaction and result build.
module teq_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  teq_pkg::t_in   i_item,
    input  teq_pkg::t_cmd  i_cmd,
    output teq_pkg::t_stat o_stat,
    output teq_pkg::t_out  o_res,
    output teq_pkg::t_out  o_fire
);
    import teq_pkg::*;

    logic [31:0]       r_slot_time [QueueDepth];
    logic [IdBits-1:0] r_slot_id   [QueueDepth];
    logic [31:0]       r_now, n_now;
    logic [CntW-1:0]   r_count;
    t_in               r_item;
    logic [CntW-1:0]   r_rd, r_wr, r_removed;
    logic [31:0]       r_limit;
    logic              r_fire_pend;
    logic [31:0]       r_fire_time;
    logic [IdBits-1:0] r_fire_id;
    logic [2:0]        r_kind;

    logic [IdxW-1:0] rd_idx, wr_idx;
    logic [31:0]     rd_time;
    logic            add_shift, match;
    logic            rd_end;

    assign rd_idx  = r_rd[IdxW-1:0];
    assign wr_idx  = r_wr[IdxW-1:0];
    assign rd_time = r_slot_time[rd_idx];
    assign rd_end  = (r_rd == r_count);
    // add: r_rd walks down from count; shift while previous entry is later
    assign add_shift = (r_rd != '0) &&
                       (r_slot_time[IdxW'(r_rd - 1'b1)] > r_item.time_value);
    assign match = (r_item.op == OP_REMOVE) ? (rd_time == r_item.time_value)
                                            : (rd_time <= r_limit);

    assign o_stat.add_done  = !add_shift;
    assign o_stat.scan_done = rd_end && !r_fire_pend;
    assign o_stat.fire_pend = r_fire_pend;

    always_comb begin
        n_now = r_now + i_item.time_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_count     <= '0;
            r_fire_pend <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_item    <= i_item;
                r_removed <= '0;
                r_wr      <= '0;
                r_limit   <= n_now;
                r_fire_pend <= 1'b0;
                if (i_item.op == OP_ADD) begin
                    r_rd <= r_count;
                    if (i_item.time_value < r_now)       r_kind <= K_REJ_PAST;
                    else if (r_count == CntW'(QueueDepth)) r_kind <= K_REJ_FULL;
                    else                                  r_kind <= K_ADDED;
                end else begin
                    r_rd   <= '0;
                    r_kind <= (i_item.op == OP_REMOVE) ? K_REMOVED : K_DONE;
                end
                if (i_item.op == OP_ADVANCE) r_now <= n_now;
            end
            if (i_cmd.add_step) begin
                if (add_shift) begin
                    r_slot_time[rd_idx] <= r_slot_time[IdxW'(r_rd - 1'b1)];
                    r_slot_id[rd_idx]   <= r_slot_id[IdxW'(r_rd - 1'b1)];
                    r_rd <= r_rd - 1'b1;
                end else begin
                    r_slot_time[rd_idx] <= r_item.time_value;
                    r_slot_id[rd_idx]   <= r_item.event_id[IdBits-1:0];
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.fire_take) r_fire_pend <= 1'b0;
            if (i_cmd.scan_step && !r_fire_pend) begin
                if (rd_end) begin
                    r_count <= r_wr;
                end else begin
                    r_rd <= r_rd + 1'b1;
                    if (match) begin
                        if (r_item.op == OP_REMOVE) begin
                            r_removed <= r_removed + 1'b1;
                        end else begin
                            r_fire_pend <= 1'b1;
                            r_fire_time <= rd_time;
                            r_fire_id   <= r_slot_id[rd_idx];
                        end
                    end else begin
                        r_slot_time[wr_idx] <= rd_time;
                        r_slot_id[wr_idx]   <= r_slot_id[rd_idx];
                        r_wr <= r_wr + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_res = '0;
        o_res.kind     = r_kind;
        o_res.now_time = r_now;
        o_res.last     = 1'b1;
        if (r_kind == K_REMOVED) o_res.removed_count = 6'(r_removed);
        o_fire = '0;
        o_fire.kind       = K_FIRED;
        o_fire.fired_id   = 16'(r_fire_id);
        o_fire.fired_time = r_fire_time;
        o_fire.now_time   = r_now;
    end
endmodule

@@ hw/rtl/teq_ctrl.sv @@
// Controller: sequencing state machine for add, remove and advance.
module teq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_op,
    input  logic           i_out_ready,
    input  logic           i_rej,
    input  teq_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output logic           o_sel_fire,
    output teq_pkg::t_cmd  o_cmd
);
    import teq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_ADD:                 n_state = S_ADD;
                        OP_REMOVE, OP_ADVANCE:  n_state = S_SCAN;
                        default:                n_state = S_RESULT;
                    endcase
                end
            end
            S_ADD:    n_state = i_rej ? S_RESULT : S_SHIFT;
            S_SHIFT:  if (i_stat.add_done) n_state = S_RESULT;
            S_SCAN: begin
                if (i_stat.fire_pend)      n_state = S_FIRE;
                else if (i_stat.scan_done) n_state = S_RESULT;
            end
            S_FIRE:   if (i_out_ready) n_state = S_SCAN;
            S_RESULT: if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_sel_fire  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_ADD: ;
            S_SHIFT:  o_cmd.add_step = 1'b1;
            S_SCAN:   o_cmd.scan_step = 1'b1;
            S_FIRE: begin
                o_out_valid     = 1'b1;
                o_sel_fire      = 1'b1;
                o_cmd.fire_take = i_out_ready;
            end
            S_RESULT: o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

@@ hw/rtl/timed_event_queue.sv @@
// Top level: time-ordered event queue with a current-time register.
// Add: accept, check, one shift per later entry, insert, result; a rejected add
// goes from check straight to result. At most 31 later entries are shifted.
// Remove/advance: accept, one scan step per queued entry plus an end step, and
// for each fired event a wait and a transfer, then result; output stalls add to it.
// One item at a time. Sync active-low reset clears time, count, control only.
module timed_event_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  teq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output teq_pkg::t_out o_out_data
);
    import teq_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_out  res, fire;
    logic  sel_fire;

    // reject kinds are decided at load; the controller only needs a flag
    logic rej;
    assign rej = (res.kind == K_REJ_PAST) || (res.kind == K_REJ_FULL);

    teq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_data.op),
        .i_out_ready (i_out_ready),
        .i_rej       (rej),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_sel_fire  (sel_fire),
        .o_cmd       (cmd)
    );

    teq_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (res),
        .o_fire  (fire)
    );

    // fired entries transfer first, then the closing result
    assign o_out_data = sel_fire ? fire : res;
endmodule
